// ===== sv/dce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dce_pkg
// Shared types, constants and the reference level decode for the dual
// comparator block.
// ----------------------------------------------------------------------------
package dce_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int FULL_SCALE  = (2 ** SAMPLE_BITS) - 1;

   // reference level N means N/1500 of full scale
   localparam int REF_BITS    = 11;
   localparam int REF_SCALE   = 1500;
   localparam int PROD_BITS   = SAMPLE_BITS + REF_BITS;

   localparam int REF_BANDGAP = 360;
   localparam int REF_SUPPLY  = 1500;
   localparam int STEP_BANDGAP = REF_BANDGAP / 60;
   localparam int STEP_SUPPLY  = REF_SUPPLY / 60;

   localparam logic [5:0] TAP_HALF  = 6'h10;
   localparam logic [5:0] TAP_3QTR  = 6'h20;
   localparam logic [5:0] TAP_FULL  = 6'h30;

   localparam logic [1:0] NEG_EXTERNAL = 2'd0;
   localparam int CSR_DATA_BITS  = 8;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COMP0_CONTROL     = 3'd0,
      CSR_COMP1_CONTROL     = 3'd1,
      CSR_COMP0_INVERT      = 3'd2,
      CSR_COMP1_INVERT      = 3'd3,
      CSR_REFERENCE_CONTROL = 3'd4,
      CSR_IRQ_ENABLE        = 3'd5,
      CSR_COMP0_PIN_ROUTE   = 3'd6,
      CSR_COMP1_PIN_ROUTE   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic       enable;
      logic [1:0] neg_sel;
      logic       invert;
   } comp_cfg_type;

   function automatic logic [REF_BITS-1:0] ref_level(input logic [7:0] ctrl);
      logic [5:0]          tap;
      logic [REF_BITS-1:0] step;
      logic [REF_BITS-1:0] src;
      logic [REF_BITS-1:0] level;
      tap  = ctrl[5:0];
      step = ctrl[7] ? REF_BITS'(STEP_BANDGAP) : REF_BITS'(STEP_SUPPLY);
      src  = ctrl[7] ? REF_BITS'(REF_BANDGAP) : REF_BITS'(REF_SUPPLY);
      if (!ctrl[6]) begin
         level = REF_BITS'(REF_BANDGAP);
      end else if (tap[5:4] == 2'b00) begin
         level = REF_BITS'(step * (REF_BITS'(tap[3:0]) + REF_BITS'(1)));
      end else begin
         case (tap)
            TAP_HALF: level = ctrl[7] ? REF_BITS'(REF_BANDGAP / 2)
                                      : REF_BITS'(REF_SUPPLY / 2);
            TAP_3QTR: level = ctrl[7] ? REF_BITS'(REF_BANDGAP * 3 / 4)
                                      : REF_BITS'(REF_SUPPLY * 3 / 4);
            TAP_FULL: level = src;
            default:  level = ctrl[7] ? REF_BITS'(REF_BANDGAP / 5)
                                      : REF_BITS'(REF_SUPPLY / 5);
         endcase
      end
      return level;
   endfunction

endpackage

// ===== sv/dce_comparator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dce_comparator
// One comparator: external pin or scaled internal reference, with polarity
// inversion. Output is 0 while disabled.
// ----------------------------------------------------------------------------
module dce_comparator
   import dce_pkg::*;
(
   input  comp_cfg_type           cfg,
   input  logic [SAMPLE_BITS-1:0] pos_sample,
   input  logic [SAMPLE_BITS-1:0] neg_sample,
   input  logic [PROD_BITS-1:0]   ref_threshold,
   output logic                   status
);

   logic [PROD_BITS-1:0] pos_scaled;
   logic                 above;

   assign pos_scaled = PROD_BITS'(pos_sample) * PROD_BITS'(REF_SCALE);

   always_comb begin
      if (cfg.neg_sel == NEG_EXTERNAL) begin
         above = pos_sample > neg_sample;
      end else begin
         above = pos_scaled > ref_threshold;
      end
   end

   assign status = cfg.enable & (above ^ cfg.invert);

endmodule

// ===== sv/dual_comparator_edge_irq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_comparator_edge_irq
// Dual analogue comparator on sampled pins with rising-edge interrupt flags.
// ----------------------------------------------------------------------------
// One result per tick transfer. Throughput is one tick per clock while the
// result side does not stall. A tick passes an input register, then the
// result register; comparison, edge detection and flag update lie between.
// Edge state and pending flags advance as each tick enters the result register,
// so ticks are processed strictly in order. No clearing pass after reset.
module dual_comparator_edge_irq
   import dce_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SAMPLE_BITS-1:0]    req_c0_pos_sample,
   input  logic [SAMPLE_BITS-1:0]    req_c0_neg_sample,
   input  logic [SAMPLE_BITS-1:0]    req_c1_pos_sample_a,
   input  logic [SAMPLE_BITS-1:0]    req_c1_pos_sample_b,
   input  logic [SAMPLE_BITS-1:0]    req_c1_pos_sample_c,
   input  logic [SAMPLE_BITS-1:0]    req_c1_pos_sample_d,
   input  logic [SAMPLE_BITS-1:0]    req_c1_neg_sample,
   input  logic [1:0]                req_flag_keep_mask,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_c0_status,
   output logic                      rsp_c1_status,
   output logic [1:0]                rsp_flag_bits,
   output logic                      rsp_irq_pulse,
   output logic                      rsp_c0_pin_drive,
   output logic [1:0]                rsp_c1_pin_drive
);

   // configuration registers
   logic [7:0] comp0_control_ff;
   logic [7:0] comp1_control_ff;
   logic       comp0_invert_ff;
   logic       comp1_invert_ff;
   logic [7:0] reference_control_ff;
   logic [1:0] irq_enable_ff;
   logic       comp0_pin_route_ff;
   logic [1:0] comp1_pin_route_ff;

   // input stage
   logic                   in_valid_ff;
   logic [SAMPLE_BITS-1:0] in_c0_pos_ff;
   logic [SAMPLE_BITS-1:0] in_c0_neg_ff;
   logic [SAMPLE_BITS-1:0] in_c1_pos_a_ff;
   logic [SAMPLE_BITS-1:0] in_c1_pos_b_ff;
   logic [SAMPLE_BITS-1:0] in_c1_pos_c_ff;
   logic [SAMPLE_BITS-1:0] in_c1_pos_d_ff;
   logic [SAMPLE_BITS-1:0] in_c1_neg_ff;
   logic [1:0]             in_keep_ff;

   // edge state
   logic       c0_previous_ff, c0_previous_in;
   logic       c0_primed_ff,   c0_primed_in;
   logic       c1_previous_ff, c1_previous_in;
   logic       c1_primed_ff,   c1_primed_in;
   logic [1:0] pending_ff,     pending_in;

   // result stage
   logic       rsp_valid_ff;
   logic       rsp_c0_status_ff;
   logic       rsp_c1_status_ff;
   logic [1:0] rsp_flag_bits_ff;
   logic       rsp_irq_pulse_ff;
   logic       rsp_c0_pin_drive_ff;
   logic [1:0] rsp_c1_pin_drive_ff;

   logic                   out_ready;
   logic                   advance;
   logic                   req_take;
   comp_cfg_type           c0_cfg;
   comp_cfg_type           c1_cfg;
   logic [PROD_BITS-1:0]   ref_threshold;
   logic [SAMPLE_BITS-1:0] c1_pos;
   logic                   c0_st;
   logic                   c1_st;
   logic                   hit0;
   logic                   hit1;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         comp0_control_ff     <= '0;
         comp1_control_ff     <= '0;
         comp0_invert_ff      <= 1'b0;
         comp1_invert_ff      <= 1'b0;
         reference_control_ff <= '0;
         irq_enable_ff        <= '0;
         comp0_pin_route_ff   <= 1'b0;
         comp1_pin_route_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_COMP0_CONTROL:     comp0_control_ff     <= csr_write_data;
            CSR_COMP1_CONTROL:     comp1_control_ff     <= csr_write_data;
            CSR_COMP0_INVERT:      comp0_invert_ff      <= csr_write_data[0];
            CSR_COMP1_INVERT:      comp1_invert_ff      <= csr_write_data[0];
            CSR_REFERENCE_CONTROL: reference_control_ff <= csr_write_data;
            CSR_IRQ_ENABLE:        irq_enable_ff        <= csr_write_data[1:0];
            CSR_COMP0_PIN_ROUTE:   comp0_pin_route_ff   <= csr_write_data[0];
            CSR_COMP1_PIN_ROUTE:   comp1_pin_route_ff   <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_c0_pos_ff   <= req_c0_pos_sample;
         in_c0_neg_ff   <= req_c0_neg_sample;
         in_c1_pos_a_ff <= req_c1_pos_sample_a;
         in_c1_pos_b_ff <= req_c1_pos_sample_b;
         in_c1_pos_c_ff <= req_c1_pos_sample_c;
         in_c1_pos_d_ff <= req_c1_pos_sample_d;
         in_c1_neg_ff   <= req_c1_neg_sample;
         in_keep_ff     <= req_flag_keep_mask;
      end
   end

   assign c0_cfg = '{enable:  comp0_control_ff[7],
                     neg_sel: comp0_control_ff[4:3],
                     invert:  comp0_invert_ff};
   assign c1_cfg = '{enable:  comp1_control_ff[7],
                     neg_sel: comp1_control_ff[4:3],
                     invert:  comp1_invert_ff};

   assign ref_threshold = PROD_BITS'(ref_level(reference_control_ff))
                        * PROD_BITS'(FULL_SCALE);

   // selects 4..7 fall back to pin a
   always_comb begin
      if (comp1_control_ff[2]) begin
         c1_pos = in_c1_pos_a_ff;
      end else begin
         case (comp1_control_ff[1:0])
            2'd0:    c1_pos = in_c1_pos_a_ff;
            2'd1:    c1_pos = in_c1_pos_b_ff;
            2'd2:    c1_pos = in_c1_pos_c_ff;
            default: c1_pos = in_c1_pos_d_ff;
         endcase
      end
   end

   dce_comparator u_comp0 (
      .cfg           (c0_cfg),
      .pos_sample    (in_c0_pos_ff),
      .neg_sample    (in_c0_neg_ff),
      .ref_threshold (ref_threshold),
      .status        (c0_st)
   );

   dce_comparator u_comp1 (
      .cfg           (c1_cfg),
      .pos_sample    (c1_pos),
      .neg_sample    (in_c1_neg_ff),
      .ref_threshold (ref_threshold),
      .status        (c1_st)
   );

   assign hit0 = c0_cfg.enable && c0_primed_ff && !c0_previous_ff && c0_st
              && irq_enable_ff[0];
   assign hit1 = c1_cfg.enable && c1_primed_ff && !c1_previous_ff && c1_st
              && irq_enable_ff[1];

   assign c0_primed_in   = c0_cfg.enable;
   assign c1_primed_in   = c1_cfg.enable;
   assign c0_previous_in = c0_cfg.enable ? c0_st : c0_previous_ff;
   assign c1_previous_in = c1_cfg.enable ? c1_st : c1_previous_ff;
   assign pending_in     = (pending_ff & in_keep_ff) | {hit1, hit0};

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_previous_ff <= 1'b0;
         c0_primed_ff   <= 1'b0;
         c1_previous_ff <= 1'b0;
         c1_primed_ff   <= 1'b0;
         pending_ff     <= '0;
      end else if (advance) begin
         c0_previous_ff <= c0_previous_in;
         c0_primed_ff   <= c0_primed_in;
         c1_previous_ff <= c1_previous_in;
         c1_primed_ff   <= c1_primed_in;
         pending_ff     <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_c0_status_ff    <= c0_st;
         rsp_c1_status_ff    <= c1_st;
         rsp_flag_bits_ff    <= pending_in;
         rsp_irq_pulse_ff    <= hit0 | hit1;
         rsp_c0_pin_drive_ff <= c0_cfg.enable & comp0_pin_route_ff;
         rsp_c1_pin_drive_ff <= c1_cfg.enable ? comp1_pin_route_ff : 2'd0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_c0_status    = rsp_c0_status_ff;
   assign rsp_c1_status    = rsp_c1_status_ff;
   assign rsp_flag_bits    = rsp_flag_bits_ff;
   assign rsp_irq_pulse    = rsp_irq_pulse_ff;
   assign rsp_c0_pin_drive = rsp_c0_pin_drive_ff;
   assign rsp_c1_pin_drive = rsp_c1_pin_drive_ff;

`ifndef SYNTHESIS
   a_pulse_has_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_irq_pulse_ff |-> rsp_flag_bits_ff != 2'b00)
      else $error("irq pulse without a pending flag");

   a_edge_needs_primed: assert property (@(posedge clock) disable iff (reset)
      advance && (hit0 || hit1) |=> (c0_primed_ff || c1_primed_ff))
      else $error("edge flagged but comparator not primed");

   a_disable_unprimes: assert property (@(posedge clock) disable iff (reset)
      advance && !c0_cfg.enable |=> !c0_primed_ff)
      else $error("comparator 0 primed after a disabled transfer");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dual comparator block. A driver feeds tick
// transfers from a queue, a monitor predicts each outcome on acceptance and
// compares every field of the result transfer. Registers are set between
// phases: a directed opening, then many random setups with random ticks.
// ----------------------------------------------------------------------------
module testbench
   import dce_pkg::*;
();

   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_CYCLES  = 80;
   localparam int ENABLE_BIT   = 7;
   localparam int TAP_STEPS    = 60;
   localparam int RANDOM_SETUPS = 14;
   localparam int TICKS_PER_SETUP = 30;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0]        c0_pos;
      logic [SAMPLE_BITS-1:0]        c0_neg;
      logic [3:0][SAMPLE_BITS-1:0]   c1_pos;
      logic [SAMPLE_BITS-1:0]        c1_neg;
      logic [1:0]                    keep;
   } tick_type;

   typedef struct packed {
      logic       c0_status;
      logic       c1_status;
      logic [1:0] flag_bits;
      logic       irq_pulse;
      logic       c0_drive;
      logic [1:0] c1_drive;
   } outcome_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_COMP0_CONTROL;
   logic [CSR_DATA_BITS-1:0]  csr_write_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [SAMPLE_BITS-1:0]    req_c0_pos_sample;
   logic [SAMPLE_BITS-1:0]    req_c0_neg_sample;
   logic [SAMPLE_BITS-1:0]    req_c1_pos_sample_a;
   logic [SAMPLE_BITS-1:0]    req_c1_pos_sample_b;
   logic [SAMPLE_BITS-1:0]    req_c1_pos_sample_c;
   logic [SAMPLE_BITS-1:0]    req_c1_pos_sample_d;
   logic [SAMPLE_BITS-1:0]    req_c1_neg_sample;
   logic [1:0]                req_flag_keep_mask;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_c0_status;
   logic                      rsp_c1_status;
   logic [1:0]                rsp_flag_bits;
   logic                      rsp_irq_pulse;
   logic                      rsp_c0_pin_drive;
   logic [1:0]                rsp_c1_pin_drive;

   tick_type    cur_tick = '0;
   tick_type    tick_queue[$];
   outcome_type outcome_queue[$];

   // register shadow
   logic [7:0] comp_ctrl [2] = '{8'h00, 8'h00};
   logic       comp_inv [2]  = '{1'b0, 1'b0};
   logic [7:0] ref_ctrl  = 8'h00;
   logic [1:0] irq_en    = 2'b00;
   logic       c0_route  = 1'b0;
   logic [1:0] c1_route  = 2'b00;

   // edge tracking state
   logic       prev_out [2] = '{1'b0, 1'b0};
   logic       primed [2]   = '{1'b0, 1'b0};
   logic [1:0] pending_flags = 2'b00;

   logic tick_taken = 1'b0;
   logic rsp_taken  = 1'b0;
   int   mismatches = 0;
   int   results_seen = 0;
   int   idle_cycles = 0;
   int   req_gap = 0;
   int   req_calm = 0;
   int   rsp_wait = 0;
   int   rsp_calm = 0;
   int   hold_left = 0;
   bit   hold_done = 1'b0;

   assign req_c0_pos_sample   = cur_tick.c0_pos;
   assign req_c0_neg_sample   = cur_tick.c0_neg;
   assign req_c1_pos_sample_a = cur_tick.c1_pos[0];
   assign req_c1_pos_sample_b = cur_tick.c1_pos[1];
   assign req_c1_pos_sample_c = cur_tick.c1_pos[2];
   assign req_c1_pos_sample_d = cur_tick.c1_pos[3];
   assign req_c1_neg_sample   = cur_tick.c1_neg;
   assign req_flag_keep_mask  = cur_tick.keep;

   dual_comparator_edge_irq u_dut (.*);

   always #5 clock = ~clock;

   // reference level as a numerator over REF_SCALE
   function automatic int reference_numerator();
      int src;
      src = ref_ctrl[7] ? REF_BANDGAP : REF_SUPPLY;
      if (!ref_ctrl[6]) return REF_BANDGAP;
      if (ref_ctrl[5:4] == 2'b00) return src * (int'(ref_ctrl[3:0]) + 1) / TAP_STEPS;
      case (ref_ctrl[5:0])
         TAP_HALF: return src / 2;
         TAP_3QTR: return src * 3 / 4;
         TAP_FULL: return src;
         default:  return src / 5;
      endcase
   endfunction

   function automatic logic comparator_level(input logic [7:0] ctrl,
                                             input logic [SAMPLE_BITS-1:0] pos,
                                             input logic [SAMPLE_BITS-1:0] neg);
      if (ctrl[4:3] == NEG_EXTERNAL) return pos > neg;
      return longint'(pos) * REF_SCALE > longint'(reference_numerator()) * FULL_SCALE;
   endfunction

   function automatic outcome_type evaluate_tick(input tick_type t);
      outcome_type o;
      logic [SAMPLE_BITS-1:0] pos;
      logic [SAMPLE_BITS-1:0] neg;
      logic level;
      o = '0;
      pending_flags = pending_flags & t.keep;
      for (int k = 0; k < 2; k++) begin
         if (!comp_ctrl[k][ENABLE_BIT]) begin
            primed[k] = 1'b0;
         end else begin
            if (k == 0) begin
               pos = t.c0_pos;
               neg = t.c0_neg;
            end else begin
               // select 4..7 falls back to pin a
               pos = comp_ctrl[1][2] ? t.c1_pos[0] : t.c1_pos[comp_ctrl[1][1:0]];
               neg = t.c1_neg;
            end
            level = comparator_level(comp_ctrl[k], pos, neg) ^ comp_inv[k];
            if (!primed[k]) begin
               primed[k] = 1'b1;
            end else if (!prev_out[k] && level && irq_en[k]) begin
               pending_flags[k] = 1'b1;
               o.irq_pulse = 1'b1;
            end
            prev_out[k] = level;
            if (k == 0) begin
               o.c0_status = level;
               o.c0_drive  = c0_route;
            end else begin
               o.c1_status = level;
               o.c1_drive  = c1_route;
            end
         end
      end
      o.flag_bits = pending_flags;
      return o;
   endfunction

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 3);
   endfunction

   task automatic check_field(input string field, input logic [1:0] want,
                              input logic [1:0] got);
      if (got !== want) begin
         mismatches++;
         $error("%s: expected %0d, got %0d", field, want, got);
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || tick_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (tick_queue.size() != 0) begin
            cur_tick  <= tick_queue.pop_front();
            req_valid <= 1'b1;
            req_gap = draw_wait(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold while the sender still has ticks queued
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 150 && tick_queue.size() >= 20) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_taken) rsp_wait = draw_wait(rsp_calm);
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      tick_taken <= !reset && req_valid && !req_stall;
      rsp_taken  <= !reset && rsp_valid && !rsp_stall;
      if (!reset) begin
         if (req_valid && !req_stall) outcome_queue.push_back(evaluate_tick(cur_tick));
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            got.c0_status = rsp_c0_status;
            got.c1_status = rsp_c1_status;
            got.flag_bits = rsp_flag_bits;
            got.irq_pulse = rsp_irq_pulse;
            got.c0_drive  = rsp_c0_pin_drive;
            got.c1_drive  = rsp_c1_pin_drive;
            if (outcome_queue.size() == 0) begin
               mismatches++;
               $error("result transfer with no outcome pending");
            end else begin
               want = outcome_queue.pop_front();
               check_field("c0_status", 2'(want.c0_status), 2'(got.c0_status));
               check_field("c1_status", 2'(want.c1_status), 2'(got.c1_status));
               check_field("flag_bits", want.flag_bits, got.flag_bits);
               check_field("irq_pulse", 2'(want.irq_pulse), 2'(got.irq_pulse));
               check_field("c0_pin_drive", 2'(want.c0_drive), 2'(got.c0_drive));
               check_field("c1_pin_drive", want.c1_drive, got.c1_drive);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("dual_comparator_edge_irq test failed");
            $finish;
         end
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [7:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_COMP0_CONTROL:     comp_ctrl[0] = data;
         CSR_COMP1_CONTROL:     comp_ctrl[1] = data;
         CSR_COMP0_INVERT:      comp_inv[0]  = data[0];
         CSR_COMP1_INVERT:      comp_inv[1]  = data[0];
         CSR_REFERENCE_CONTROL: ref_ctrl     = data;
         CSR_IRQ_ENABLE:        irq_en       = data[1:0];
         CSR_COMP0_PIN_ROUTE:   c0_route     = data[0];
         CSR_COMP1_PIN_ROUTE:   c1_route     = data[1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setup(input logic [7:0] c0c, input logic [7:0] c1c,
                              input logic [7:0] inv0, input logic [7:0] inv1,
                              input logic [7:0] refc, input logic [7:0] irq,
                              input logic [7:0] r0, input logic [7:0] r1);
      csr_write(CSR_COMP0_CONTROL, c0c);
      csr_write(CSR_COMP1_CONTROL, c1c);
      csr_write(CSR_COMP0_INVERT, inv0);
      csr_write(CSR_COMP1_INVERT, inv1);
      csr_write(CSR_REFERENCE_CONTROL, refc);
      csr_write(CSR_IRQ_ENABLE, irq);
      csr_write(CSR_COMP0_PIN_ROUTE, r0);
      csr_write(CSR_COMP1_PIN_ROUTE, r1);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_setup(input int variant);
      logic [7:0] c0c;
      logic [7:0] c1c;
      logic [5:0] tap;
      if (variant == 0) begin
         apply_setup(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      end else if (variant == 1) begin
         apply_setup(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      end else begin
         c0c = 8'($urandom);
         c1c = 8'($urandom);
         if ($urandom_range(0, 3) != 0) c0c[ENABLE_BIT] = 1'b1;
         if ($urandom_range(0, 3) != 0) c1c[ENABLE_BIT] = 1'b1;
         case ($urandom_range(0, 5))
            0, 1:    tap = 6'($urandom_range(0, 15));
            2:       tap = TAP_HALF;
            3:       tap = TAP_3QTR;
            4:       tap = TAP_FULL;
            default: tap = 6'($urandom);
         endcase
         apply_setup(c0c, c1c, 8'($urandom), 8'($urandom),
                     {2'($urandom_range(0, 3)), tap}, 8'($urandom),
                     8'($urandom), 8'($urandom));
      end
   endtask

   function automatic tick_type make_tick(input int c0p, input int c0n, input int pa,
                                          input int pb, input int pc, input int pd,
                                          input int c1n, input int keep);
      tick_type t;
      t.c0_pos    = SAMPLE_BITS'(c0p);
      t.c0_neg    = SAMPLE_BITS'(c0n);
      t.c1_pos[0] = SAMPLE_BITS'(pa);
      t.c1_pos[1] = SAMPLE_BITS'(pb);
      t.c1_pos[2] = SAMPLE_BITS'(pc);
      t.c1_pos[3] = SAMPLE_BITS'(pd);
      t.c1_neg    = SAMPLE_BITS'(c1n);
      t.keep      = 2'(keep);
      return t;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] near_level(input longint centre);
      longint v;
      v = centre + longint'($urandom_range(0, 8)) - 4;
      if (v < 0) v = 0;
      if (v > FULL_SCALE) v = FULL_SCALE;
      return v[SAMPLE_BITS-1:0];
   endfunction

   // samples cluster around the switching point so the outputs toggle
   function automatic tick_type random_tick();
      tick_type t;
      int       sel;
      longint   thr;
      t.c0_pos    = SAMPLE_BITS'($urandom);
      t.c0_neg    = SAMPLE_BITS'($urandom);
      t.c1_pos[0] = SAMPLE_BITS'($urandom);
      t.c1_pos[1] = SAMPLE_BITS'($urandom);
      t.c1_pos[2] = SAMPLE_BITS'($urandom);
      t.c1_pos[3] = SAMPLE_BITS'($urandom);
      t.c1_neg    = SAMPLE_BITS'($urandom);
      t.keep      = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : 2'b11;
      thr = longint'(reference_numerator()) * FULL_SCALE / REF_SCALE;
      if ($urandom_range(0, 3) != 0) begin
         if (comp_ctrl[0][4:3] == NEG_EXTERNAL) t.c0_pos = near_level(t.c0_neg);
         else t.c0_pos = near_level(thr);
      end
      sel = comp_ctrl[1][2] ? 0 : int'(comp_ctrl[1][1:0]);
      if ($urandom_range(0, 3) != 0) begin
         if (comp_ctrl[1][4:3] == NEG_EXTERNAL) t.c1_pos[sel] = near_level(t.c1_neg);
         else t.c1_pos[sel] = near_level(thr);
      end
      return t;
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (tick_queue.size() != 0 || req_valid || outcome_queue.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // everything disabled after reset
      tick_queue.push_back(make_tick(4095, 0, 4095, 0, 4095, 0, 0, 0));
      tick_queue.push_back(make_tick(0, 4095, 0, 4095, 0, 4095, 4095, 3));
      wait_drained();

      // external negatives: priming, edges, repeat edge on a set flag, clears
      apply_setup(8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h03, 8'h01, 8'h03);
      tick_queue.push_back(make_tick(4095, 0, 4095, 0, 0, 0, 0, 3));
      tick_queue.push_back(make_tick(0, 4095, 0, 4095, 4095, 4095, 4095, 3));
      tick_queue.push_back(make_tick(4095, 4094, 4095, 0, 0, 0, 4094, 3));
      tick_queue.push_back(make_tick(4095, 4095, 4095, 0, 0, 0, 4095, 3));
      tick_queue.push_back(make_tick(1, 0, 1, 0, 0, 0, 0, 3));
      tick_queue.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
      tick_queue.push_back(make_tick(0, 1, 4095, 0, 0, 0, 0, 1));
      wait_drained();

      // bandgap tap reference, inversion, fallback pin select, irq off
      apply_setup(8'h88, 8'h95, 8'h01, 8'h01, 8'hC0, 8'h00, 8'h00, 8'h01);
      tick_queue.push_back(make_tick(16, 0, 17, 4095, 4095, 4095, 0, 3));
      tick_queue.push_back(make_tick(17, 0, 16, 0, 0, 0, 0, 3));
      tick_queue.push_back(make_tick(4095, 4095, 0, 4095, 4095, 4095, 4095, 3));
      wait_drained();

      // full supply reference on comparator 0, pin d on comparator 1
      apply_setup(8'h98, 8'h83, 8'h00, 8'h00, 8'h70, 8'h01, 8'h01, 8'h02);
      tick_queue.push_back(make_tick(4095, 0, 0, 0, 0, 4095, 4094, 3));
      tick_queue.push_back(make_tick(4095, 0, 4095, 4095, 4095, 0, 4094, 3));
      wait_drained();

      for (int s = 0; s < RANDOM_SETUPS; s++) begin
         random_setup(s);
         for (int n = 0; n < TICKS_PER_SETUP; n++) tick_queue.push_back(random_tick());
         wait_drained();
      end

      if (mismatches == 0) begin
         $display("dual_comparator_edge_irq test passed");
      end else begin
         $display("dual_comparator_edge_irq test failed");
      end
      $finish;
   end

endmodule
